### hw/rtl/kli_pkg.sv
// Shared types and constants of the keyframe linear interpolator.
// No dependencies; used by kli_ctrl, kli_dp and the top level.
package kli_pkg;

    // Widths fixed by the item fields
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned SLOT_W  = 6;
    localparam int unsigned COUNT_W = 7;
    // Fraction is unsigned Q1.16 in [0, 1.0], so 17 bits
    localparam int unsigned FRAC_W    = 17;
    localparam int unsigned DIV_STEPS = 17;
    localparam int unsigned DIV_CNT_W = 5;
    // Product of a 33-bit difference and the 18-bit signed fraction
    localparam int unsigned PROD_W = 51;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // One table entry
    typedef struct packed {
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
    } t_key;

    // Controller to datapath commands
    typedef struct packed {
        logic key_write;  // store the input entry
        logic start;      // latch query time and key count
        logic rd_first;   // read entry 0
        logic rd_next;    // read the entry after the current one
        logic take_prev;  // current entry becomes the earlier key
        logic load_cur;   // result = current entry
        logic load_prev;  // result = earlier key
        logic div_init;   // set up the fraction division
        logic div_step;   // one quotient bit
        logic mul_step;   // one blend multiply / add slot
        logic load_out;   // result into output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic first_hit;  // one key, or time at or before key 0
        logic pair_hit;   // earlier key and current entry enclose the time
        logic den_zero;   // enclosing interval has zero length
        logic at_last;    // current entry is the last valid key
        logic div_done;   // last quotient bit in this cycle
        logic mul_done;   // last component written in this cycle
    } t_dp_sts;

endpackage

### hw/rtl/keyframe_linear_interpolator_top.sv
// Top level of the keyframe linear interpolator.
// Depends on kli_pkg, kli_ctrl and kli_dp.
//
// Keyframe writes (kind 0) are stored without leaving the idle state and
// produce no result. A query (kind 1) is handled one at a time: the key table
// is a single memory read one entry per cycle, so a query scans the entries in
// order until a pair encloses its time, then runs the bit-serial fraction
// divider and the shared blend multiplier; the result is then loaded into the
// output register once that is free. A time at or before the first key, a
// zero-length interval, or a time that no pair encloses skips the divider and
// the multiplier. No clearing pass is run after reset; slots must be written
// before they are read.
module keyframe_linear_interpolator_top #(
    parameter int unsigned MAX_KEYS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic [5:0]         i_key_index,
    input  logic [31:0]        i_time_point,
    input  logic signed [31:0] i_value_x,
    input  logic signed [31:0] i_value_y,
    input  logic signed [31:0] i_value_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z
);

    kli_pkg::t_dp_cmd cmd;
    kli_pkg::t_dp_sts sts;

    // Sequencer
    kli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Table and arithmetic
    kli_dp #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_key_index  (i_key_index),
        .i_time_point (i_time_point),
        .i_value_x    (i_value_x),
        .i_value_y    (i_value_y),
        .i_value_z    (i_value_z),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z)
    );

endmodule

### hw/rtl/kli_ctrl.sv
// Sequencer of the keyframe linear interpolator: handshakes and command flow.
// Depends on kli_pkg for the command and status structs.
module kli_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_kind,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  kli_pkg::t_dp_sts  i_sts,
    output kli_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FIRST = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DIV   = 6'b001000,
        S_MUL   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   in_accept;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_kind == kli_pkg::KIND_WRITE) begin
                        o_cmd.key_write = 1'b1;
                    end else begin
                        o_cmd.start    = 1'b1;
                        o_cmd.rd_first = 1'b1;
                        n_state        = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                if (i_sts.first_hit) begin
                    o_cmd.load_cur = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.take_prev = 1'b1;
                    o_cmd.rd_next   = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.pair_hit && i_sts.den_zero) begin
                    o_cmd.load_prev = 1'b1;
                    n_state         = S_DONE;
                end else if (i_sts.pair_hit) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else if (i_sts.at_last) begin
                    o_cmd.load_cur = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.take_prev = 1'b1;
                    o_cmd.rd_next   = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // z is added in the cycle that flags done
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### hw/rtl/kli_dp.sv
// Datapath of the keyframe linear interpolator: key table, scan registers,
// serial fraction divider, shared blend multiplier. Depends on kli_pkg.
module kli_dp #(
    parameter int unsigned MAX_KEYS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [kli_pkg::COUNT_W-1:0]  i_cfg_data,
    input  logic [kli_pkg::SLOT_W-1:0]   i_key_index,
    input  logic [kli_pkg::WORD_W-1:0]   i_time_point,
    input  logic signed [kli_pkg::WORD_W-1:0] i_value_x,
    input  logic signed [kli_pkg::WORD_W-1:0] i_value_y,
    input  logic signed [kli_pkg::WORD_W-1:0] i_value_z,
    input  kli_pkg::t_dp_cmd             i_cmd,
    output kli_pkg::t_dp_sts             o_sts,
    output logic signed [kli_pkg::WORD_W-1:0] o_out_x,
    output logic signed [kli_pkg::WORD_W-1:0] o_out_y,
    output logic signed [kli_pkg::WORD_W-1:0] o_out_z
);

    localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int unsigned NW = $clog2(MAX_KEYS + 1);
    localparam int unsigned CW = (NW > kli_pkg::COUNT_W) ? NW : kli_pkg::COUNT_W;
    localparam int unsigned SW = ((AW > kli_pkg::SLOT_W) ? AW : kli_pkg::SLOT_W) + 1;
    localparam int unsigned WW = kli_pkg::WORD_W;

    kli_pkg::t_key r_mem [MAX_KEYS];
    kli_pkg::t_key r_rd;
    kli_pkg::t_key r_prev;

    logic [kli_pkg::COUNT_W-1:0]  r_key_count;
    logic [NW-1:0]                r_num_keys;
    logic [WW-1:0]                r_t;
    logic [AW-1:0]                r_addr;
    logic [WW-1:0]                r_den;
    logic [WW-1:0]                r_rem;
    logic                         r_num_bit;
    logic [kli_pkg::FRAC_W-1:0]   r_frac;
    logic [kli_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [1:0]                   r_comp;
    logic signed [kli_pkg::PROD_W-1:0] r_prod;
    logic [WW-1:0]                r_res_x;
    logic [WW-1:0]                r_res_y;
    logic [WW-1:0]                r_res_z;
    logic [WW-1:0]                r_out_x;
    logic [WW-1:0]                r_out_y;
    logic [WW-1:0]                r_out_z;

    logic [CW-1:0]  count_ext;
    logic [CW-1:0]  count_clamp;
    logic           slot_ok;
    logic [AW-1:0]  wr_addr;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [WW-1:0]  elapsed;
    logic [WW:0]    div_trial;
    logic [WW-1:0]  mul_a;
    logic [WW-1:0]  mul_b;
    logic signed [WW:0] mul_diff;
    logic [WW-1:0]  add_a;
    logic [WW-1:0]  add_sum;

    // Key count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= kli_pkg::COUNT_W'(1);
        end else if (i_cfg_we) begin
            r_key_count <= i_cfg_data;
        end
    end

    // Effective count: zero acts as one, clamp to table depth
    always_comb begin
        count_ext = CW'(r_key_count);
        if (count_ext == '0) begin
            count_clamp = CW'(1);
        end else if (count_ext > CW'(MAX_KEYS)) begin
            count_clamp = CW'(MAX_KEYS);
        end else begin
            count_clamp = count_ext;
        end
    end

    // Table write and registered read
    assign slot_ok = SW'(i_key_index) < SW'(MAX_KEYS);
    assign wr_addr = AW'(i_key_index);
    assign rd_en   = i_cmd.rd_first || i_cmd.rd_next;
    assign rd_addr = i_cmd.rd_first ? '0 : r_addr + AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_write && slot_ok) begin
            r_mem[wr_addr] <= '{t: i_time_point, x: i_value_x, y: i_value_y, z: i_value_z};
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Query and scan registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (rd_en) begin
            r_addr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_t        <= i_time_point;
            r_num_keys <= count_clamp[NW-1:0];
        end
        if (i_cmd.take_prev) begin
            r_prev <= r_rd;
        end
    end

    // Scan status
    assign o_sts.first_hit = (r_num_keys == NW'(1)) || (r_t <= r_rd.t);
    assign o_sts.pair_hit  = (r_prev.t <= r_t) && (r_t <= r_rd.t);
    assign o_sts.den_zero  = (r_rd.t == r_prev.t);
    assign o_sts.at_last   = (NW'(r_addr) == (r_num_keys - NW'(1)));
    assign o_sts.div_done  = (r_div_cnt == '0);
    assign o_sts.mul_done  = (r_comp == 2'd3);

    // Restoring division of (t - t0) << 16 by (t1 - t0), one bit a cycle.
    // Quotient is at most 1.0, so only the low 17 numerator bits need steps;
    // the bits above seed the remainder.
    assign elapsed   = r_t - r_prev.t;
    assign div_trial = {r_rem, r_num_bit} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_den     <= r_rd.t - r_prev.t;
            r_rem     <= elapsed >> 1;
            r_num_bit <= elapsed[0];
            r_frac    <= '0;
            r_div_cnt <= kli_pkg::DIV_CNT_W'(kli_pkg::DIV_STEPS - 1);
        end else if (i_cmd.div_step) begin
            r_num_bit <= 1'b0;
            r_div_cnt <= r_div_cnt - kli_pkg::DIV_CNT_W'(1);
            if (!div_trial[WW]) begin
                r_rem  <= div_trial[WW-1:0];
                r_frac <= {r_frac[kli_pkg::FRAC_W-2:0], 1'b1};
            end else begin
                r_rem  <= {r_rem[WW-2:0], r_num_bit};
                r_frac <= {r_frac[kli_pkg::FRAC_W-2:0], 1'b0};
            end
        end
    end

    // Component select for the multiply slot
    always_comb begin
        case (r_comp)
            2'd0: begin
                mul_a = r_prev.x;
                mul_b = r_rd.x;
            end
            2'd1: begin
                mul_a = r_prev.y;
                mul_b = r_rd.y;
            end
            default: begin
                mul_a = r_prev.z;
                mul_b = r_rd.z;
            end
        endcase
    end

    // Component select for the add slot, which lags the multiply: it adds the component whose product r_prod holds
    always_comb begin
        case (r_comp)
            2'd1:    add_a = r_prev.x;
            2'd2:    add_a = r_prev.y;
            default: add_a = r_prev.z;
        endcase
    end

    // a + floor((b - a) * f / 2^16); dropping the low 16 product bits floors
    assign mul_diff = $signed({mul_b[WW-1], mul_b}) - $signed({mul_a[WW-1], mul_a});
    assign add_sum  = add_a + r_prod[WW+15:16];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_comp <= '0;
        end else if (i_cmd.mul_step) begin
            r_comp <= r_comp + 2'd1;
            if (r_comp != 2'd3) begin
                r_prod <= mul_diff * $signed({1'b0, r_frac});
            end
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cur) begin
            r_res_x <= r_rd.x;
            r_res_y <= r_rd.y;
            r_res_z <= r_rd.z;
        end else if (i_cmd.load_prev) begin
            r_res_x <= r_prev.x;
            r_res_y <= r_prev.y;
            r_res_z <= r_prev.z;
        end else if (i_cmd.mul_step) begin
            case (r_comp)
                2'd1:    r_res_x <= add_sum;
                2'd2:    r_res_y <= add_sum;
                2'd3:    r_res_z <= add_sum;
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_x <= r_res_x;
            r_out_y <= r_res_y;
            r_out_z <= r_res_z;
        end
    end

    assign o_out_x = r_out_x;
    assign o_out_y = r_out_y;
    assign o_out_z = r_out_z;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for keyframe_linear_interpolator_top: keyframe loads, key count
// settings and interpolated queries, checked against an in-bench interpolator using a Q1.16 fraction.
// Depends on kli_pkg and the keyframe_linear_interpolator_top RTL.
module tb_top;
    import kli_pkg::*;

    localparam int unsigned TABLE_DEPTH   = 64;
    localparam int unsigned SETTLE_CYCLES = 100;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned IDLE_PCT      = 32;

    typedef struct packed {
        logic signed [WORD_W-1:0] x;
        logic signed [WORD_W-1:0] y;
        logic signed [WORD_W-1:0] z;
    } vec_t;

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_cfg_we     = 1'b0;
    logic [COUNT_W-1:0]        i_cfg_data   = '0;
    logic                      i_in_valid   = 1'b0;
    logic                      o_in_ready;
    logic                      i_kind       = KIND_WRITE;
    logic [SLOT_W-1:0]         i_key_index  = '0;
    logic [WORD_W-1:0]         i_time_point = '0;
    logic signed [WORD_W-1:0]  i_value_x    = '0;
    logic signed [WORD_W-1:0]  i_value_y    = '0;
    logic signed [WORD_W-1:0]  i_value_z    = '0;
    logic                      o_out_valid;
    logic                      i_out_ready  = 1'b0;
    logic signed [WORD_W-1:0]  o_out_x;
    logic signed [WORD_W-1:0]  o_out_y;
    logic signed [WORD_W-1:0]  o_out_z;

    // Local copy of the key table and the count register
    logic [WORD_W-1:0]         key_time_tbl [TABLE_DEPTH];
    logic signed [WORD_W-1:0]  key_x_tbl    [TABLE_DEPTH];
    logic signed [WORD_W-1:0]  key_y_tbl    [TABLE_DEPTH];
    logic signed [WORD_W-1:0]  key_z_tbl    [TABLE_DEPTH];
    logic [COUNT_W-1:0]        key_count_reg = 1;

    // Interpolated vectors still owed by the block, oldest first
    vec_t owed_vecs [$];

    bit          no_gaps      = 1'b0;
    int unsigned mismatches   = 0;
    int unsigned n_writes     = 0;
    int unsigned n_queries    = 0;
    int unsigned n_results    = 0;
    int unsigned n_cfg_writes = 0;

    keyframe_linear_interpolator_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_key_index  (i_key_index),
        .i_time_point (i_time_point),
        .i_value_x    (i_value_x),
        .i_value_y    (i_value_y),
        .i_value_z    (i_value_z),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // a + floor((b - a) * frac / 2^16); frac is in [0, 65536]
    function automatic logic signed [WORD_W-1:0] lerp_comp(input logic signed [WORD_W-1:0] a,
                                                           input logic signed [WORD_W-1:0] b,
                                                           input longint frac);
        longint prod;
        prod = (longint'(b) - longint'(a)) * frac;
        return WORD_W'(longint'(a) + (prod >>> 16));
    endfunction

    // Expected answer for a query at time t with the current table and count
    function automatic vec_t interpolate_at(input logic [WORD_W-1:0] t);
        int unsigned       n;
        logic [WORD_W-1:0] t0;
        logic [WORD_W-1:0] t1;
        logic [63:0]       num;
        logic [63:0]       den;
        longint            frac;
        vec_t              v;
        n = (key_count_reg == 0) ? 1 :
            (key_count_reg > TABLE_DEPTH) ? TABLE_DEPTH : key_count_reg;
        v.x = key_x_tbl[0];
        v.y = key_y_tbl[0];
        v.z = key_z_tbl[0];
        if (n == 1 || t <= key_time_tbl[0])
            return v;
        // first adjacent pair that encloses t
        for (int i = 0; i + 1 < n; i++) begin
            t0 = key_time_tbl[i];
            t1 = key_time_tbl[i+1];
            if (t0 <= t && t <= t1) begin
                if (t0 == t1) begin
                    v.x = key_x_tbl[i];
                    v.y = key_y_tbl[i];
                    v.z = key_z_tbl[i];
                    return v;
                end
                num  = {16'h0, t - t0, 16'h0};
                den  = {32'h0, t1 - t0};
                frac = longint'(num / den);
                v.x  = lerp_comp(key_x_tbl[i], key_x_tbl[i+1], frac);
                v.y  = lerp_comp(key_y_tbl[i], key_y_tbl[i+1], frac);
                v.z  = lerp_comp(key_z_tbl[i], key_z_tbl[i+1], frac);
                return v;
            end
        end
        // nothing encloses t: hold the last valid key
        v.x = key_x_tbl[n-1];
        v.y = key_y_tbl[n-1];
        v.z = key_z_tbl[n-1];
        return v;
    endfunction

    // Send one request and update the local model when it is taken
    task automatic send_item(input logic kind, input logic [SLOT_W-1:0] slot,
                             input logic [WORD_W-1:0] t,
                             input logic signed [WORD_W-1:0] x,
                             input logic signed [WORD_W-1:0] y,
                             input logic signed [WORD_W-1:0] z);
        if (!no_gaps) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_key_index  <= slot;
        i_time_point <= t;
        i_value_x    <= x;
        i_value_y    <= y;
        i_value_z    <= z;
        do @(posedge i_clk); while (!o_in_ready);
        if (kind == KIND_WRITE) begin
            key_time_tbl[slot] = t;
            key_x_tbl[slot]    = x;
            key_y_tbl[slot]    = y;
            key_z_tbl[slot]    = z;
            n_writes++;
        end else begin
            owed_vecs.push_back(interpolate_at(t));
            n_queries++;
        end
    endtask

    task automatic write_key(input logic [SLOT_W-1:0] slot, input logic [WORD_W-1:0] t,
                             input logic signed [WORD_W-1:0] x,
                             input logic signed [WORD_W-1:0] y,
                             input logic signed [WORD_W-1:0] z);
        send_item(KIND_WRITE, slot, t, x, y, z);
    endtask

    // Unused fields of a query carry random bits
    task automatic query(input logic [WORD_W-1:0] t);
        send_item(KIND_QUERY, SLOT_W'($urandom()), t, $urandom(), $urandom(), $urandom());
    endtask

    // Hold the sender until every owed result is out, then let the block settle
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (owed_vecs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_key_count(input logic [COUNT_W-1:0] value);
        drain_block();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        key_count_reg = value;
        n_cfg_writes++;
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Load slots 0..n-1, ascending times (with repeats) or scrambled ones
    task automatic load_table(input int unsigned n, input bit ascending);
        logic [WORD_W-1:0] t;
        t = ascending ? $urandom_range(32'h4000_0000, 0) : $urandom();
        for (int unsigned s = 0; s < n; s++) begin
            write_key(SLOT_W'(s), t, rand_word(), rand_word(), rand_word());
            if (!ascending)
                t = $urandom();
            else
                case ($urandom_range(7))
                    0:       ;  // repeated key time
                    1, 2, 3: t += $urandom_range(32'h100, 1);
                    default: t += $urandom_range(32'h0080_0000, 1);
                endcase
        end
    endtask

    // Query times aimed at the loaded table: inside pairs, on keys, past the ends, or fully random
    function automatic logic [WORD_W-1:0] pick_query_time(input int unsigned n);
        int unsigned j;
        j = $urandom_range(n - 1, 0);
        case ($urandom_range(9))
            0:       return $urandom();
            1:       return key_time_tbl[0] - $urandom_range(32'h1000, 0);
            2:       return key_time_tbl[n-1] + $urandom_range(32'h1000, 0);
            3, 4:    return key_time_tbl[j];
            default: begin
                if (j + 1 < n)
                    return $urandom_range(key_time_tbl[j+1], key_time_tbl[j]);
                return key_time_tbl[j] + 1;
            end
        endcase
    endfunction

    task automatic mixed_traffic(input int unsigned n, input int unsigned count);
        repeat (count) begin
            if ($urandom_range(9) == 0)
                write_key(SLOT_W'($urandom_range(n - 1, 0)), $urandom(), rand_word(),
                          rand_word(), rand_word());
            else
                query(pick_query_time(n));
        end
    endtask

    // Count out of reset is 1: only key 0 answers
    task automatic test_single_key();
        write_key(0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        query(32'h0000_0000);
        query(32'h0005_0000);
        query(32'hFFFF_FFFF);
    endtask

    // Two keys with opposite extreme x and y values, probed across and around the interval
    task automatic test_two_key_span();
        logic [WORD_W-1:0] probe [9] = '{32'h0, 32'h0001_0000, 32'h0001_0001, 32'h0001_8000,
                                         32'h0002_0000, 32'h0002_FFFF, 32'h0003_0000,
                                         32'h0003_0001, 32'hFFFF_FFFF};
        write_key(1, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
        set_key_count(2);
        foreach (probe[i])
            query(probe[i]);
    endtask

    task automatic test_odd_tables();
        // repeated key time
        write_key(1, 32'h0001_0000, 32'h1234_5678, 32'h0, 32'hFFFF_0000);
        query(32'h0001_0000);
        query(32'h0001_0001);
        // interval spanning the whole 32-bit time range
        write_key(0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        write_key(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        query(32'h0000_0001);
        query(32'h8000_0000);
        query(32'hFFFF_FFFE);
        // descending keys: the query time is at or before key 0, so key 0 answers
        write_key(0, 32'h0005_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
        write_key(1, 32'h0002_0000, 32'h0002_0000, 32'hFFFE_0000, 32'h7FFF_FFFF);
        query(32'h0003_0000);
        // count of zero behaves as one
        set_key_count(0);
        query(32'h0004_0000);
    endtask

    // Every slot written; count at 64, above the table size and at 1
    task automatic test_full_table();
        load_table(TABLE_DEPTH, 1'b1);
        set_key_count(TABLE_DEPTH);
        repeat (24) query(pick_query_time(TABLE_DEPTH));
        set_key_count(65);
        repeat (8) query(pick_query_time(TABLE_DEPTH));
        set_key_count(127);
        repeat (8) query(pick_query_time(TABLE_DEPTH));
        set_key_count(1);
        repeat (4) query(pick_query_time(TABLE_DEPTH));
    endtask

    task automatic test_random_tables(input int unsigned target);
        int unsigned      sent_base;
        int unsigned      n;
        logic [COUNT_W-1:0] cnt;
        sent_base = n_writes + n_queries;
        while (n_writes + n_queries - sent_base < target) begin
            n = ($urandom_range(3) == 0) ? $urandom_range(TABLE_DEPTH, 2) : $urandom_range(8, 2);
            load_table(n, $urandom_range(3) != 0);
            case ($urandom_range(7))
                0:       cnt = 0;
                1:       cnt = COUNT_W'($urandom_range(127, 65));
                2:       cnt = 1;
                default: cnt = COUNT_W'(n);
            endcase
            set_key_count(cnt);
            mixed_traffic(n, $urandom_range(30, 6));
        end
    endtask

    // Neither side idles here
    task automatic test_back_to_back();
        no_gaps = 1'b1;
        load_table(16, 1'b1);
        set_key_count(16);
        mixed_traffic(16, 150);
        drain_block();
        no_gaps = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: out_%s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Result side: random back-pressure unless no_gaps is set
    always @(posedge i_clk) begin
        i_out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare each delivered vector with the oldest owed one
    always @(posedge i_clk) begin
        vec_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_vecs.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h %h %h",
                         $time, o_out_x, o_out_y, o_out_z);
            end else begin
                want = owed_vecs.pop_front();
                check_field("x", want.x, o_out_x);
                check_field("y", want.y, o_out_y);
                check_field("z", want.z, o_out_z);
                n_results++;
            end
        end
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: timeout with %0d results outstanding", $time, owed_vecs.size());
        $display("keyframe_linear_interpolator_top verification failed");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_key();
        test_two_key_span();
        test_odd_tables();
        test_full_table();
        test_random_tables(800);
        test_back_to_back();
        drain_block();

        $display("Ran %0d queries (%0d results checked) and %0d keyframe writes,",
                 n_queries, n_results, n_writes);
        $display("over %0d key count settings including 0, 1, 64, 65 and 127.", n_cfg_writes);
        if (mismatches == 0)
            $display("keyframe_linear_interpolator_top verification clean");
        else
            $display("keyframe_linear_interpolator_top verification failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/kli_pkg.sv
hw/rtl/kli_ctrl.sv
hw/rtl/kli_dp.sv
hw/rtl/keyframe_linear_interpolator_top.sv
verif/tb_top.sv
